>>> hw/rtl/split_row_best_subset_match_core_macros.svh
// assertion macros for the split row best match block
// needs clk and rst in the scope of each use
`ifndef SPLIT_ROW_BEST_SUBSET_MATCH_CORE_MACROS_SVH
`define SPLIT_ROW_BEST_SUBSET_MATCH_CORE_MACROS_SVH

// same-cycle implication, switched off during reset
`define SRBSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, switched off during reset
`define SRBSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/srbsm_pkg.sv
// shared constants and types for the split row best match block
// no dependencies
package srbsm_pkg;

  localparam int MAX_LEAVES_DEF = 64;
  localparam int TABLE_ROWS_DEF = 256;

  // fixed field widths on the channels
  localparam int OP_W     = 1;
  localparam int IDX_W    = 8;
  localparam int MASK_W   = 64;
  localparam int CNT_W    = 7;
  localparam int LC_W     = 7;
  // popcount tree is built for the widest leaf set
  localparam int LEAF_PAD = 64;

  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  // status of one row leaving the compare and count unit
  typedef struct packed {
    logic vld;
    logic hit;
  } eval_stat_t;

endpackage

>>> hw/rtl/srbsm_if.sv
// word channels of the split row best match block: request, response, config
// depends on srbsm_pkg
interface srbsm_in_if import srbsm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  row_index;
  logic [MASK_W-1:0] mask_bits;

  modport source (output valid, output operation, output row_index, output mask_bits,
                  input ready);
  modport sink   (input valid, input operation, input row_index, input mask_bits,
                  output ready);
endinterface

interface srbsm_out_if import srbsm_pkg::*;;
  logic             valid;
  logic             ready;
  logic             found;
  logic [IDX_W-1:0] best_row;
  logic [CNT_W-1:0] other_count;

  modport source (output valid, output found, output best_row, output other_count,
                  input ready);
  modport sink   (input valid, input found, input best_row, input other_count,
                  output ready);
endinterface

interface srbsm_cfg_if import srbsm_pkg::*;;
  logic            valid;
  logic            ready;
  logic [LC_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/srbsm_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module srbsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hw/rtl/srbsm_eval.sv
// shared compare and popcount unit, one stored row per cycle, registered result
// depends on srbsm_pkg
module srbsm_eval import srbsm_pkg::*; #(
  parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_vld,
  input  logic                             row_ok,
  input  logic [MAX_LEAVES-1:0]            row,
  input  logic [MAX_LEAVES-1:0]            query,
  input  logic [MAX_LEAVES-1:0]            lmask,
  output eval_stat_t                       stat,
  output logic [$clog2(MAX_LEAVES+1)-1:0]  cost
);

  localparam int CW = $clog2(MAX_LEAVES + 1);

  logic [MAX_LEAVES-1:0] side_a;
  logic [MAX_LEAVES-1:0] pop_op;
  logic                  is_sub;
  logic                  is_dis;
  logic [LEAF_PAD-1:0]   pc_in;
  logic [1:0]            p1 [LEAF_PAD/2];
  logic [2:0]            p2 [LEAF_PAD/4];
  logic [3:0]            p3 [LEAF_PAD/8];
  logic [4:0]            p4 [LEAF_PAD/16];
  logic [5:0]            p5 [LEAF_PAD/32];
  logic [6:0]            p6;

  always_comb begin
    side_a = row & lmask;
    is_sub = ((query & ~side_a) == '0);
    is_dis = ((query & side_a) == '0);
    // one count serves both sides: the row side or its complement
    pop_op = is_sub ? (side_a & ~query) : (lmask & ~side_a & ~query);
    pc_in  = LEAF_PAD'(pop_op);
    for (int i = 0; i < LEAF_PAD/2; i++) begin
      p1[i] = {1'b0, pc_in[2*i]} + {1'b0, pc_in[2*i+1]};
    end
    for (int i = 0; i < LEAF_PAD/4; i++) begin
      p2[i] = {1'b0, p1[2*i]} + {1'b0, p1[2*i+1]};
    end
    for (int i = 0; i < LEAF_PAD/8; i++) begin
      p3[i] = {1'b0, p2[2*i]} + {1'b0, p2[2*i+1]};
    end
    for (int i = 0; i < LEAF_PAD/16; i++) begin
      p4[i] = {1'b0, p3[2*i]} + {1'b0, p3[2*i+1]};
    end
    for (int i = 0; i < LEAF_PAD/32; i++) begin
      p5[i] = {1'b0, p4[2*i]} + {1'b0, p4[2*i+1]};
    end
    p6 = {1'b0, p5[0]} + {1'b0, p5[1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.vld <= in_vld;
      stat.hit <= in_vld & row_ok & (is_sub | is_dis);
    end
    cost <= CW'(p6);
  end

endmodule

>>> hw/rtl/split_row_best_subset_match_core.sv
// load: the next word is taken in the following cycle
// query: one ram read per row, then a registered compare and count; the best row
//   is then registered as the response, and only then is a new word taken
// after reset the valid ram is cleared one row a cycle, no word is taken until all
//   rows are cleared; config is taken at any time, leaf count resets to MAX_LEAVES
module split_row_best_subset_match_core import srbsm_pkg::*; #(
  parameter int MAX_LEAVES = MAX_LEAVES_DEF,
  parameter int TABLE_ROWS = TABLE_ROWS_DEF
) (
  input logic         clk,
  input logic         rst,
  srbsm_in_if.sink    req,
  srbsm_out_if.source rsp,
  srbsm_cfg_if.sink   cfg
);

  localparam int AW = $clog2(TABLE_ROWS);
  localparam int CW = $clog2(MAX_LEAVES + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t                state;
  logic [AW-1:0]         cnt;
  logic [MAX_LEAVES-1:0] lmask;
  logic [MAX_LEAVES-1:0] lmask_next;
  logic [MAX_LEAVES-1:0] query;
  logic                  s1_vld;
  logic [AW-1:0]         s1_idx;
  logic [AW-1:0]         s2_idx;
  logic                  found;
  logic [AW-1:0]         best_idx;
  logic [CW-1:0]         best_cost;
  logic                  rsp_valid;
  logic                  rsp_found;
  logic [IDX_W-1:0]      rsp_row;
  logic [CNT_W-1:0]      rsp_count;

  logic                  req_acc;
  logic                  is_load;
  logic                  in_range;
  logic [MAX_LEAVES-1:0] load_row;
  logic [LC_W-1:0]       lc_sat;
  logic                  row_we;
  logic [AW-1:0]         row_waddr;
  logic                  vld_we;
  logic [AW-1:0]         vld_waddr;
  logic [0:0]            vld_wdata;
  logic                  rd_en;
  logic [MAX_LEAVES-1:0] row_rd;
  logic [0:0]            vld_rd;
  logic                  cnt_last;
  logic                  drained;
  logic                  upd;
  eval_stat_t            stat;
  logic [CW-1:0]         cost;

  assign req.ready   = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign rsp.valid   = rsp_valid;
  assign rsp.found   = rsp_found;
  assign rsp.best_row    = rsp_row;
  assign rsp.other_count = rsp_count;

  always_comb begin
    req_acc  = req.valid & req.ready;
    is_load  = (req.operation == OP_LOAD);
    in_range = (32'(req.row_index) < TABLE_ROWS);
    // stored rows keep leaf 0 on their clear side
    load_row = req.mask_bits[MAX_LEAVES-1:0] & lmask;
    if (load_row[0]) begin
      load_row = ~load_row & lmask;
    end

    if (cfg.data > LC_W'(MAX_LEAVES)) begin
      lc_sat = LC_W'(MAX_LEAVES);
    end else begin
      lc_sat = cfg.data;
    end
    for (int i = 0; i < MAX_LEAVES; i++) begin
      lmask_next[i] = (LC_W'(i) < lc_sat);
    end

    row_we    = req_acc & is_load & in_range;
    row_waddr = AW'(req.row_index);
    vld_we    = row_we | (state == ST_CLEAR);
    vld_waddr = (state == ST_CLEAR) ? cnt : row_waddr;
    vld_wdata = (state == ST_CLEAR) ? 1'b0 : 1'b1;
    rd_en     = (state == ST_SCAN);
    cnt_last  = (cnt == AW'(TABLE_ROWS - 1));
    drained   = ~s1_vld & ~stat.vld;
    // strict compare keeps the lowest row on a tie
    upd       = stat.vld & stat.hit & (~found | (cost < best_cost));
  end

  srbsm_ram #(.WIDTH(MAX_LEAVES), .DEPTH(TABLE_ROWS)) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_waddr),
    .wr_data (load_row),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (row_rd)
  );

  srbsm_ram #(.WIDTH(1), .DEPTH(TABLE_ROWS)) u_vld_ram (
    .clk     (clk),
    .wr_en   (vld_we),
    .wr_addr (vld_waddr),
    .wr_data (vld_wdata),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (vld_rd)
  );

  srbsm_eval #(.MAX_LEAVES(MAX_LEAVES)) u_eval (
    .clk    (clk),
    .rst    (rst),
    .in_vld (s1_vld),
    .row_ok (vld_rd[0]),
    .row    (row_rd),
    .query  (query),
    .lmask  (lmask),
    .stat   (stat),
    .cost   (cost)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      lmask     <= '1;
      s1_vld    <= 1'b0;
      found     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      s1_vld <= (state == ST_SCAN);
      s1_idx <= cnt;
      s2_idx <= s1_idx;
      if (cfg.valid && cfg.ready) begin
        lmask <= lmask_next;
      end
      if (rsp_valid && rsp.ready && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end
      if (upd) begin
        found     <= 1'b1;
        best_idx  <= s2_idx;
        best_cost <= cost;
      end
      case (state)
        ST_CLEAR: begin
          cnt <= cnt + AW'(1);
          if (cnt_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req_acc && !is_load) begin
            query <= req.mask_bits[MAX_LEAVES-1:0] & lmask;
            cnt   <= '0;
            found <= 1'b0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + AW'(1);
          if (cnt_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (drained) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // wait for the output register to be free
          if (!rsp_valid || rsp.ready) begin
            rsp_valid <= 1'b1;
            rsp_found <= found;
            rsp_row   <= found ? IDX_W'(best_idx) : '0;
            rsp_count <= found ? CNT_W'(best_cost) : '0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/srbsm_checker.sv
// port-level checks for the split row best match block, bound to the top level
// depends on srbsm_pkg and the assertion macro header
`include "split_row_best_subset_match_core_macros.svh"

module srbsm_checker import srbsm_pkg::*; #(
  parameter int MAX_LEAVES = MAX_LEAVES_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             req_valid,
  input logic             req_ready,
  input logic [OP_W-1:0]  req_operation,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input logic             rsp_found,
  input logic [IDX_W-1:0] rsp_best_row,
  input logic [CNT_W-1:0] rsp_other_count
);

  `SRBSM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_found, rsp_best_row, rsp_other_count}), "response word changed while stalled")
  `SRBSM_ASSERT_IMP(a_miss_zero, rsp_valid && !rsp_found, rsp_best_row == '0 && rsp_other_count == '0, "no match but row or count not zero")
  `SRBSM_ASSERT_IMP(a_count_range, rsp_valid, rsp_other_count <= CNT_W'(MAX_LEAVES), "count above leaf limit")
  `SRBSM_ASSERT_NEXT(a_query_busy, req_valid && req_ready && req_operation == OP_QUERY, !req_ready, "request taken during a query scan")

endmodule

bind split_row_best_subset_match_core srbsm_checker #(.MAX_LEAVES(MAX_LEAVES)) u_chk (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .req_operation   (req.operation),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_found       (rsp.found),
  .rsp_best_row    (rsp.best_row),
  .rsp_other_count (rsp.other_count)
);
